// ----- hw/rtl/frame_table_clock_replacement_defines.svh -----
// Assertion macros for the frame table checker.
// Included by the checker file only.
`ifndef FRAME_TABLE_CLOCK_REPLACEMENT_DEFINES_SVH
`define FRAME_TABLE_CLOCK_REPLACEMENT_DEFINES_SVH
// implication check, reset-qualified
`define FTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// next-cycle check, reset-qualified
`define FTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

// ----- hw/rtl/ftcr_pkg.sv -----
// Shared types and constants for the frame table with clock eviction.
// No dependencies.
`default_nettype none
package ftcr_pkg;
	localparam int TableEntries = 64;
	localparam int SlotBits = $clog2(TableEntries);
	localparam int FrameBits = 20;
	localparam int OwnerBits = 8;
	localparam int VpageBits = 20;

	typedef logic [2:0] opcode_t;
	localparam opcode_t OP_INSERT = 3'd0;
	localparam opcode_t OP_FREE = 3'd1;
	localparam opcode_t OP_FIND = 3'd2;
	localparam opcode_t OP_FIND_ADD = 3'd3;
	localparam opcode_t OP_PIN = 3'd4;
	localparam opcode_t OP_TOUCH = 3'd5;
	localparam opcode_t OP_EVICT = 3'd6;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_FULL = 2'd1;
	localparam status_t ST_NOT_FOUND = 2'd2;
	localparam status_t ST_NO_VICTIM = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN, S_PASS2_RD, S_PASS2, S_WRITE,
		S_EV_RD, S_EV_CHK, S_CNT_RD, S_CNT, S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;    // capture request
		logic clr_scan;    // clear per-pass scan results
		logic rd_en;       // read slot rd_addr
		logic [SlotBits-1:0] rd_addr;
		logic eval_scan;   // evaluate read slot for pass 1 / pass 2
		logic eval_pass2;
		logic eval_cnt;    // evaluate read slot for refcount of victim
		logic ev_take;     // latch current read as evict candidate
		logic ev_clear_acc;
		logic commit;      // final state update
		logic evict_commit;
		logic no_victim;
		logic hand_adv;
	} ftcr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		opcode_t op;
		logic [SlotBits-1:0] hand;
		logic ev_skip;     // read slot free, pinned or accessed
		logic ev_accessed;
		logic cnt_multi;   // victim frame has another mapping
	} ftcr_sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/ftcr_ctrl.sv -----
// Sequencer for table scans and the clock hand walk.
// Depends on ftcr_pkg.
`default_nettype none
module ftcr_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire logic out_stall,
	output ftcr_pkg::ftcr_cmd_t cmd,
	input  wire ftcr_pkg::ftcr_sts_t sts
);
	ftcr_pkg::state_t state_q, state_d;
	logic [ftcr_pkg::SlotBits:0] idx_q, idx_d;
	logic [ftcr_pkg::SlotBits+1:0] evn_q, evn_d;
	logic ov_q, ov_d;
	localparam logic [ftcr_pkg::SlotBits:0] LastIdx =
		(ftcr_pkg::SlotBits+1)'(ftcr_pkg::TableEntries - 1);
	localparam logic [ftcr_pkg::SlotBits+1:0] EvLimit =
		(ftcr_pkg::SlotBits+2)'(2 * ftcr_pkg::TableEntries);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ftcr_pkg::S_IDLE;
			idx_q <= '0;
			evn_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			evn_q <= evn_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;
	assign in_stall = (state_q != ftcr_pkg::S_IDLE) || ov_q;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		evn_d = evn_q;
		ov_d = ov_q && out_stall;
		cmd = '0;
		cmd.rd_addr = idx_q[ftcr_pkg::SlotBits-1:0];
		unique case (state_q)
			ftcr_pkg::S_IDLE: begin
				if (in_valid && !in_stall) begin
					cmd.load_req = 1'b1;
					cmd.clr_scan = 1'b1;
					idx_d = '0;
					evn_d = '0;
					state_d = ftcr_pkg::S_SCAN_RD;
				end
			end
			ftcr_pkg::S_SCAN_RD: begin
				if (sts.op == ftcr_pkg::OP_EVICT) begin
					state_d = ftcr_pkg::S_EV_RD;
				end else begin
					cmd.rd_en = 1'b1;
					state_d = ftcr_pkg::S_SCAN;
				end
			end
			ftcr_pkg::S_SCAN: begin
				cmd.eval_scan = 1'b1;
				if (idx_q == LastIdx) begin
					idx_d = '0;
					state_d = ftcr_pkg::S_PASS2_RD;
				end else begin
					idx_d = idx_q + 1'b1;
					cmd.rd_en = 1'b1;
					cmd.rd_addr = idx_d[ftcr_pkg::SlotBits-1:0];
				end
			end
			ftcr_pkg::S_PASS2_RD: begin
				if (sts.op == ftcr_pkg::OP_FREE) begin
					cmd.rd_en = 1'b1;
					state_d = ftcr_pkg::S_PASS2;
				end else begin
					state_d = ftcr_pkg::S_WRITE;
				end
			end
			ftcr_pkg::S_PASS2: begin
				// free needs the full refcount before picking by owner
				cmd.eval_pass2 = 1'b1;
				if (idx_q == LastIdx) begin
					state_d = ftcr_pkg::S_WRITE;
				end else begin
					idx_d = idx_q + 1'b1;
					cmd.rd_en = 1'b1;
					cmd.rd_addr = idx_d[ftcr_pkg::SlotBits-1:0];
				end
			end
			ftcr_pkg::S_WRITE: begin
				cmd.commit = 1'b1;
				state_d = ftcr_pkg::S_DONE;
			end
			ftcr_pkg::S_EV_RD: begin
				if (evn_q == EvLimit) begin
					cmd.no_victim = 1'b1;
					state_d = ftcr_pkg::S_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					cmd.rd_addr = sts.hand;
					state_d = ftcr_pkg::S_EV_CHK;
				end
			end
			ftcr_pkg::S_EV_CHK: begin
				cmd.hand_adv = 1'b1;
				evn_d = evn_q + 1'b1;
				if (sts.ev_skip) begin
					cmd.ev_clear_acc = sts.ev_accessed;
					state_d = ftcr_pkg::S_EV_RD;
				end else begin
					cmd.ev_take = 1'b1;
					cmd.clr_scan = 1'b1;
					idx_d = '0;
					state_d = ftcr_pkg::S_CNT_RD;
				end
			end
			ftcr_pkg::S_CNT_RD: begin
				cmd.rd_en = 1'b1;
				state_d = ftcr_pkg::S_CNT;
			end
			ftcr_pkg::S_CNT: begin
				cmd.eval_cnt = 1'b1;
				if (idx_q == LastIdx) begin
					state_d = ftcr_pkg::S_WRITE;
				end else begin
					idx_d = idx_q + 1'b1;
					cmd.rd_en = 1'b1;
					cmd.rd_addr = idx_d[ftcr_pkg::SlotBits-1:0];
				end
				if (sts.cnt_multi && idx_q == LastIdx) begin
					state_d = ftcr_pkg::S_EV_RD;
				end
				if (!sts.cnt_multi && idx_q == LastIdx) begin
					cmd.evict_commit = 1'b1;
					state_d = ftcr_pkg::S_DONE;
				end
			end
			ftcr_pkg::S_DONE: begin
				ov_d = 1'b1;
				state_d = ftcr_pkg::S_IDLE;
			end
			default: state_d = ftcr_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ----- hw/rtl/ftcr_datapath.sv -----
// Slot store, per-slot marks, scan accumulators and result register.
// Depends on ftcr_pkg.
`default_nettype none
module ftcr_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ftcr_pkg::ftcr_cmd_t cmd,
	output ftcr_pkg::ftcr_sts_t sts,
	input  wire logic [2:0] opcode,
	input  wire logic [ftcr_pkg::FrameBits-1:0] frame_number,
	input  wire logic [ftcr_pkg::OwnerBits-1:0] owner_id,
	input  wire logic [ftcr_pkg::VpageBits-1:0] virtual_page,
	input  wire logic [31:0] file_key,
	input  wire logic [31:0] page_offset,
	input  wire logic file_backed,
	input  wire logic pin_value,
	output logic [1:0] status,
	output logic [ftcr_pkg::FrameBits-1:0] frame_out,
	output logic [ftcr_pkg::OwnerBits-1:0] owner_out,
	output logic [ftcr_pkg::VpageBits-1:0] virtual_page_out,
	output logic page_released
);
	localparam int SB = ftcr_pkg::SlotBits;
	localparam int N = ftcr_pkg::TableEntries;
	localparam int RecW = ftcr_pkg::FrameBits + ftcr_pkg::OwnerBits + ftcr_pkg::VpageBits + 64;

	// payload memory: frame, owner, vpage, key, offset
	logic [RecW-1:0] mem [N];
	logic [RecW-1:0] rd_q;
	logic [SB-1:0] rdaddr_q;
	logic [N-1:0] valid_q, backed_q, pin_q, acc_q;

	// captured request
	ftcr_pkg::opcode_t op_q;
	logic [ftcr_pkg::FrameBits-1:0] fr_q;
	logic [ftcr_pkg::OwnerBits-1:0] own_q;
	logic [ftcr_pkg::VpageBits-1:0] vp_q;
	logic [31:0] key_q, off_q;
	logic bk_q, pv_q;

	// scan accumulators
	logic src_hit_q, fr_hit_q, own_hit_q, touch_hit_q;
	logic [SB-1:0] fr_slot_q, own_slot_q;
	logic [1:0] refs_q;
	logic [ftcr_pkg::FrameBits-1:0] src_fr_q;
	logic [31:0] src_key_q, src_off_q;
	logic [N-1:0] touch_q;
	logic [SB-1:0] hand_q;
	logic [SB-1:0] vic_q;
	logic [ftcr_pkg::FrameBits-1:0] vfr_q;
	logic [ftcr_pkg::OwnerBits-1:0] vown_q;
	logic [ftcr_pkg::VpageBits-1:0] vvp_q;
	logic [1:0] cnt_q;

	logic [ftcr_pkg::FrameBits-1:0] r_fr;
	logic [ftcr_pkg::OwnerBits-1:0] r_own;
	logic [ftcr_pkg::VpageBits-1:0] r_vp;
	logic [31:0] r_key, r_off;
	logic r_val, r_bk;
	assign {r_fr, r_own, r_vp, r_key, r_off} = rd_q;
	assign r_val = valid_q[rdaddr_q];
	assign r_bk = backed_q[rdaddr_q];

	logic [SB-1:0] lowest_free;
	logic any_free;
	always_comb begin
		lowest_free = '0;
		any_free = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				lowest_free = SB'(i);
				any_free = 1'b1;
			end
		end
	end

	// decision for commit
	logic wr_en, wr_bk, clr_en, pin_en;
	logic [SB-1:0] wr_slot, clr_slot;
	logic [RecW-1:0] wr_data;
	ftcr_pkg::status_t st_d;
	logic [ftcr_pkg::FrameBits-1:0] fo_d;
	logic rel_d;
	always_comb begin
		wr_en = 1'b0; wr_bk = 1'b0; clr_en = 1'b0; pin_en = 1'b0;
		wr_slot = lowest_free; clr_slot = fr_slot_q;
		wr_data = {fr_q, own_q, vp_q, 64'd0};
		st_d = ftcr_pkg::ST_OK; fo_d = '0; rel_d = 1'b0;
		unique case (op_q)
			ftcr_pkg::OP_INSERT: begin
				if (!any_free) st_d = ftcr_pkg::ST_FULL;
				else begin
					wr_en = 1'b1;
					if (src_hit_q) begin
						wr_bk = 1'b1;
						wr_data = {fr_q, own_q, vp_q, src_key_q, src_off_q};
					end else begin
						wr_bk = bk_q;
						wr_data = {fr_q, own_q, vp_q, bk_q ? key_q : 32'd0, bk_q ? off_q : 32'd0};
					end
				end
			end
			ftcr_pkg::OP_FREE: begin
				if (refs_q == 2'd0) st_d = ftcr_pkg::ST_NOT_FOUND;
				else if (refs_q == 2'd1) begin
					clr_en = 1'b1; rel_d = 1'b1;
				end else if (own_hit_q) begin
					clr_en = 1'b1; clr_slot = own_slot_q;
				end else st_d = ftcr_pkg::ST_NOT_FOUND;
			end
			ftcr_pkg::OP_FIND, ftcr_pkg::OP_FIND_ADD: begin
				if (!src_hit_q) st_d = ftcr_pkg::ST_NOT_FOUND;
				else if (op_q == ftcr_pkg::OP_FIND) fo_d = src_fr_q;
				else if (!any_free) st_d = ftcr_pkg::ST_FULL;
				else begin
					wr_en = 1'b1; wr_bk = 1'b1; fo_d = src_fr_q;
					wr_data = {src_fr_q, own_q, vp_q, src_key_q, src_off_q};
				end
			end
			ftcr_pkg::OP_PIN: begin
				if (fr_hit_q) pin_en = 1'b1;
				else st_d = ftcr_pkg::ST_NOT_FOUND;
			end
			ftcr_pkg::OP_TOUCH: begin
				if (!touch_hit_q) st_d = ftcr_pkg::ST_NOT_FOUND;
			end
			default: ;
		endcase
	end

	assign sts.op = op_q;
	assign sts.hand = hand_q;
	assign sts.ev_skip = !r_val || pin_q[rdaddr_q] || acc_q[rdaddr_q];
	assign sts.ev_accessed = r_val && !pin_q[rdaddr_q] && acc_q[rdaddr_q];
	assign sts.cnt_multi = (cnt_q + 2'(r_val && r_fr == vfr_q)) >= 2'd2
		|| cnt_q >= 2'd2;

	// payload memory
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem[cmd.rd_addr];
			rdaddr_q <= cmd.rd_addr;
		end
		if (cmd.commit && wr_en) mem[wr_slot] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0; backed_q <= '0; pin_q <= '0; acc_q <= '0;
			hand_q <= '0; op_q <= '0;
			status <= '0; frame_out <= '0; owner_out <= '0;
			virtual_page_out <= '0; page_released <= 1'b0;
		end else begin
			if (cmd.load_req) begin
				op_q <= opcode;
			end
			if (cmd.hand_adv) hand_q <= hand_q + 1'b1;
			if (cmd.ev_clear_acc) acc_q[rdaddr_q] <= 1'b0;
			if (cmd.commit) begin
				if (wr_en) begin
					valid_q[wr_slot] <= 1'b1; backed_q[wr_slot] <= wr_bk;
					pin_q[wr_slot] <= 1'b0; acc_q[wr_slot] <= 1'b0;
				end
				if (clr_en) valid_q[clr_slot] <= 1'b0;
				if (pin_en) pin_q[fr_slot_q] <= pv_q;
				if (op_q == ftcr_pkg::OP_TOUCH) acc_q <= acc_q | touch_q;
				status <= st_d; frame_out <= fo_d; owner_out <= '0;
				virtual_page_out <= '0; page_released <= rel_d;
			end
			if (cmd.evict_commit) begin
				valid_q[vic_q] <= 1'b0;
				status <= ftcr_pkg::ST_OK; frame_out <= vfr_q; owner_out <= vown_q;
				virtual_page_out <= vvp_q; page_released <= 1'b1;
			end
			if (cmd.no_victim) begin
				status <= ftcr_pkg::ST_NO_VICTIM; frame_out <= '0; owner_out <= '0;
				virtual_page_out <= '0; page_released <= 1'b0;
			end
		end
	end

	// request capture and scan accumulators (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			fr_q <= frame_number; own_q <= owner_id; vp_q <= virtual_page;
			key_q <= file_key; off_q <= page_offset; bk_q <= file_backed;
			pv_q <= pin_value;
		end
		if (cmd.clr_scan) begin
			src_hit_q <= 1'b0; fr_hit_q <= 1'b0; own_hit_q <= 1'b0;
			touch_hit_q <= 1'b0; refs_q <= '0; touch_q <= '0; cnt_q <= '0;
		end
		if (cmd.eval_scan && r_val) begin
			if (op_q == ftcr_pkg::OP_INSERT) begin
				if (!src_hit_q && r_bk && r_fr == fr_q) begin
					src_hit_q <= 1'b1; src_key_q <= r_key; src_off_q <= r_off;
				end
			end else if (!src_hit_q && r_bk && r_key == key_q && r_off == off_q) begin
				src_hit_q <= 1'b1; src_fr_q <= r_fr; src_key_q <= r_key;
				src_off_q <= r_off;
			end
			if (r_fr == fr_q) begin
				if (!fr_hit_q) begin
					fr_hit_q <= 1'b1; fr_slot_q <= rdaddr_q;
				end
				if (refs_q != 2'd2) refs_q <= refs_q + 1'b1;
			end
			if (r_own == own_q && r_vp == vp_q) begin
				touch_hit_q <= 1'b1; touch_q[rdaddr_q] <= 1'b1;
			end
		end
		if (cmd.eval_pass2 && r_val && !own_hit_q && r_fr == fr_q && r_own == own_q) begin
			own_hit_q <= 1'b1; own_slot_q <= rdaddr_q;
		end
		if (cmd.ev_take) begin
			vic_q <= rdaddr_q; vfr_q <= r_fr; vown_q <= r_own; vvp_q <= r_vp;
		end
		if (cmd.eval_cnt && r_val && r_fr == vfr_q && cnt_q != 2'd2) cnt_q <= cnt_q + 1'b1;
	end
endmodule
`default_nettype wire

// ----- hw/rtl/frame_table_clock_replacement.sv -----
// Top level of the frame table with clock (second-chance) eviction.
// Depends on ftcr_pkg, ftcr_ctrl and ftcr_datapath.
//
// One request in, one result out, both on valid/stall channels.
// A request is taken only while no earlier result waits; in_stall is high
// during the whole operation and while the result is held.
// Insert, find, pin and touch take one table sweep; free takes two sweeps
// (refcount, then owner match). Evict visits slots from the hand one by one,
// and for each candidate sweeps the table once to count references; in the
// worst case the hand makes two revolutions. Sweeps are needed because the
// slot memory has a single read port.
// Reset clears valid, pinned, accessed and file-backed marks and the hand;
// the slot payload memory is not cleared.
// A stalled result holds its value until out_stall drops.
`default_nettype none
module frame_table_clock_replacement (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [2:0] opcode,
	input  wire logic [19:0] frame_number,
	input  wire logic [7:0] owner_id,
	input  wire logic [19:0] virtual_page,
	input  wire logic [31:0] file_key,
	input  wire logic [31:0] page_offset,
	input  wire logic file_backed,
	input  wire logic pin_value,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [1:0] status,
	output logic [19:0] frame_out,
	output logic [7:0] owner_out,
	output logic [19:0] virtual_page_out,
	output logic page_released
);
	ftcr_pkg::ftcr_cmd_t cmd;
	ftcr_pkg::ftcr_sts_t sts;

	ftcr_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.cmd, .sts
	);

	ftcr_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .opcode, .frame_number, .owner_id,
		.virtual_page, .file_key, .page_offset, .file_backed, .pin_value,
		.status, .frame_out, .owner_out, .virtual_page_out, .page_released
	);
endmodule
`default_nettype wire

// ----- hw/rtl/ftcr_checker.sv -----
// Port-level checker for the frame table, bound to the top level.
// Depends on frame_table_clock_replacement_defines.svh.
`default_nettype none
`include "frame_table_clock_replacement_defines.svh"
module ftcr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [1:0] status,
	input wire logic [19:0] frame_out,
	input wire logic [7:0] owner_out,
	input wire logic page_released
);
	// a request is never taken while a result is pending
	`FTC_ASSERT_IMP(a_no_take_while_out, clk, arst_n, out_valid, in_stall)
	// held result stays valid and keeps its frame_out value
	`FTC_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(frame_out))
	// owner is reported only by a successful eviction
	`FTC_ASSERT_IMP(a_owner, clk, arst_n, out_valid && owner_out != 8'd0, page_released)
	// no release together with an error status
	`FTC_ASSERT_IMP(a_rel, clk, arst_n, out_valid && page_released, status == ftcr_pkg::ST_OK)
	// accepted request produces no result in the next cycle
	`FTC_ASSERT_NXT(a_lat, clk, arst_n, in_valid && !in_stall, !out_valid)
endmodule

bind frame_table_clock_replacement ftcr_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.status, .frame_out, .owner_out, .page_released
);
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for the frame table with clock eviction: drives directed and random requests,
// predicts every result with a behavioral table model and checks each field.
// Depends on ftcr_pkg and frame_table_clock_replacement.
`default_nettype none
module tb_top;
	localparam int Slots = ftcr_pkg::TableEntries;

	typedef struct {
		ftcr_pkg::status_t st;
		logic [19:0] frame;
		logic [7:0] owner;
		logic [19:0] vpage;
		logic rel;
	} result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic out_stall = 0;
	logic [2:0] opcode = '0;
	logic [19:0] frame_number = '0;
	logic [7:0] owner_id = '0;
	logic [19:0] virtual_page = '0;
	logic [31:0] file_key = '0;
	logic [31:0] page_offset = '0;
	logic file_backed = 0;
	logic pin_value = 0;
	logic in_stall, out_valid, page_released;
	logic [1:0] status;
	logic [19:0] frame_out, virtual_page_out;
	logic [7:0] owner_out;

	frame_table_clock_replacement uut (.*);

	// table model
	logic m_valid [Slots];
	logic [19:0] m_frame [Slots];
	logic [7:0] m_owner [Slots];
	logic [19:0] m_vpage [Slots];
	logic m_backed [Slots];
	logic [31:0] m_key [Slots];
	logic [31:0] m_off [Slots];
	logic m_pin [Slots];
	logic m_acc [Slots];
	int hand = 0;

	result_t pending_results[$];
	int errors = 0;
	bit idle_on = 1;

	initial forever #1 clk = ~clk;

	initial begin
		#50000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int lowest_free();
		for (int s = 0; s < Slots; s++)
			if (!m_valid[s]) return s;
		return -1;
	endfunction

	function automatic int frame_refs(logic [19:0] f);
		int n;
		n = 0;
		for (int s = 0; s < Slots; s++)
			if (m_valid[s] && m_frame[s] == f) n++;
		return n;
	endfunction

	function automatic void fill(int s, logic [19:0] f, logic [7:0] o, logic [19:0] v,
			logic b, logic [31:0] k, logic [31:0] off);
		m_valid[s] = 1; m_frame[s] = f; m_owner[s] = o; m_vpage[s] = v;
		m_backed[s] = b; m_key[s] = b ? k : '0; m_off[s] = b ? off : '0;
		m_pin[s] = 0; m_acc[s] = 0;
	endfunction

	function automatic result_t apply_request(logic [2:0] op, logic [19:0] f, logic [7:0] o,
			logic [19:0] v, logic [31:0] k, logic [31:0] off, logic b, logic p);
		result_t r;
		int slot, hit, n, h;
		r = '{ftcr_pkg::ST_OK, '0, '0, '0, 0};
		case (op)
			ftcr_pkg::OP_INSERT: begin
				slot = lowest_free();
				if (slot < 0) r.st = ftcr_pkg::ST_FULL;
				else begin
					hit = -1;
					for (int s = 0; s < Slots; s++)
						if (hit < 0 && m_valid[s] && m_frame[s] == f && m_backed[s]) hit = s;
					if (hit >= 0) fill(slot, f, o, v, 1, m_key[hit], m_off[hit]);
					else fill(slot, f, o, v, b, k, off);
				end
			end
			ftcr_pkg::OP_FREE: begin
				n = frame_refs(f);
				if (n == 0) r.st = ftcr_pkg::ST_NOT_FOUND;
				else if (n == 1) begin
					for (int s = 0; s < Slots; s++)
						if (m_valid[s] && m_frame[s] == f) m_valid[s] = 0;
					r.rel = 1;
				end else begin
					r.st = ftcr_pkg::ST_NOT_FOUND;
					for (int s = 0; s < Slots; s++)
						if (r.st != ftcr_pkg::ST_OK && m_valid[s] && m_frame[s] == f
								&& m_owner[s] == o) begin
							m_valid[s] = 0;
							r.st = ftcr_pkg::ST_OK;
						end
				end
			end
			ftcr_pkg::OP_FIND, ftcr_pkg::OP_FIND_ADD: begin
				hit = -1;
				for (int s = 0; s < Slots; s++)
					if (hit < 0 && m_valid[s] && m_backed[s] && m_key[s] == k && m_off[s] == off)
						hit = s;
				if (hit < 0) r.st = ftcr_pkg::ST_NOT_FOUND;
				else if (op == ftcr_pkg::OP_FIND) r.frame = m_frame[hit];
				else begin
					slot = lowest_free();
					if (slot < 0) r.st = ftcr_pkg::ST_FULL;
					else begin
						fill(slot, m_frame[hit], o, v, 1, m_key[hit], m_off[hit]);
						r.frame = m_frame[hit];
					end
				end
			end
			ftcr_pkg::OP_PIN: begin
				r.st = ftcr_pkg::ST_NOT_FOUND;
				for (int s = 0; s < Slots; s++)
					if (r.st != ftcr_pkg::ST_OK && m_valid[s] && m_frame[s] == f) begin
						m_pin[s] = p;
						r.st = ftcr_pkg::ST_OK;
					end
			end
			ftcr_pkg::OP_TOUCH: begin
				r.st = ftcr_pkg::ST_NOT_FOUND;
				for (int s = 0; s < Slots; s++)
					if (m_valid[s] && m_owner[s] == o && m_vpage[s] == v) begin
						m_acc[s] = 1;
						r.st = ftcr_pkg::ST_OK;
					end
			end
			ftcr_pkg::OP_EVICT: begin
				r.st = ftcr_pkg::ST_NO_VICTIM;
				for (int i = 0; i < 2 * Slots && r.st != ftcr_pkg::ST_OK; i++) begin
					h = hand;
					hand = (h + 1) % Slots;
					if (!m_valid[h] || m_pin[h]) continue;
					if (m_acc[h]) begin
						m_acc[h] = 0;
						continue;
					end
					if (frame_refs(m_frame[h]) > 1) continue;
					m_valid[h] = 0;
					r = '{ftcr_pkg::ST_OK, m_frame[h], m_owner[h], m_vpage[h], 1};
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t e;
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.st) begin
					$error("status exp %0d got %0d", e.st, status); errors++;
				end
				if (frame_out !== e.frame) begin
					$error("frame_out exp %h got %h", e.frame, frame_out); errors++;
				end
				if (owner_out !== e.owner) begin
					$error("owner_out exp %h got %h", e.owner, owner_out); errors++;
				end
				if (virtual_page_out !== e.vpage) begin
					$error("virtual_page_out exp %h got %h", e.vpage, virtual_page_out);
					errors++;
				end
				if (page_released !== e.rel) begin
					$error("page_released exp %0d got %0d", e.rel, page_released); errors++;
				end
			end
		end
	end

	// receiver stall bursts
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 3);
				out_stall <= 1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 0;
		end
	end

	// valid stays high into the next request unless an idle burst comes first
	task automatic send_request(logic [2:0] op, logic [19:0] f, logic [7:0] o, logic [19:0] v,
			logic [31:0] k, logic [31:0] off, logic b, logic p);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		opcode <= op; frame_number <= f; owner_id <= o; virtual_page <= v;
		file_key <= k; page_offset <= off; file_backed <= b; pin_value <= p;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(apply_request(op, f, o, v, k, off, b, p));
		@(negedge clk);
	endtask

	// small pools so that lookups, frees and touches hit often
	task automatic send_random(int pool);
		logic [2:0] op;
		logic [19:0] f, v;
		logic [31:0] k, off;
		int pick;
		pick = $urandom_range(0, 9);
		op = (pick > 6) ? ftcr_pkg::OP_INSERT : 3'(pick);
		f = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, pool));
		v = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, pool));
		k = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
		off = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
		send_request(op, f, 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 3)),
			v, k, off, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	task automatic test_directed();
		send_request(ftcr_pkg::OP_EVICT, 0, 0, 0, 0, 0, 0, 0);	// empty table
		send_request(ftcr_pkg::OP_FREE, 5, 0, 0, 0, 0, 0, 0);
		send_request(ftcr_pkg::OP_INSERT, '1, '1, '1, '1, '1, 1, 1);
		send_request(ftcr_pkg::OP_INSERT, 0, 0, 0, 0, 0, 0, 0);
		send_request(ftcr_pkg::OP_FIND, 0, 0, 0, '1, '1, 0, 0);
		send_request(ftcr_pkg::OP_FIND_ADD, 7, 3, 9, '1, '1, 0, 0);
		send_request(ftcr_pkg::OP_INSERT, '1, 4, 4, 1, 1, 0, 0);	// copies file identity
		send_request(ftcr_pkg::OP_FIND, 0, 0, 0, 1, 1, 0, 0);
		send_request(ftcr_pkg::OP_PIN, 0, 0, 0, 0, 0, 0, 1);
		send_request(ftcr_pkg::OP_PIN, 123, 0, 0, 0, 0, 0, 1);
		send_request(ftcr_pkg::OP_TOUCH, 0, '1, '1, 0, 0, 0, 0);
		send_request(ftcr_pkg::OP_TOUCH, 0, 1, 1, 0, 0, 0, 0);
		send_request(3'd7, '1, '1, '1, '1, '1, 1, 1);	// unused opcode
		send_request(ftcr_pkg::OP_EVICT, 0, 0, 0, 0, 0, 0, 0);	// shared and pinned skipped
		send_request(ftcr_pkg::OP_FREE, '1, 77, 0, 0, 0, 0, 0);
		send_request(ftcr_pkg::OP_FREE, '1, 3, 0, 0, 0, 0, 0);
		send_request(ftcr_pkg::OP_PIN, 0, 0, 0, 0, 0, 0, 0);
		send_request(ftcr_pkg::OP_EVICT, 0, 0, 0, 0, 0, 0, 0);
		send_request(ftcr_pkg::OP_FREE, '1, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_table_full();
		for (int i = 0; i < Slots + 2; i++)
			send_request(ftcr_pkg::OP_INSERT, 20'(i + 100), 8'(i), 20'(i), 32'(i), 0, i[0], 0);
		send_request(ftcr_pkg::OP_FIND_ADD, 0, 1, 1, 1, 0, 0, 0);
		for (int i = 0; i < Slots; i += 2)
			send_request(ftcr_pkg::OP_TOUCH, 0, 8'(i), 20'(i), 0, 0, 0, 0);
		repeat (Slots + 4) send_request(ftcr_pkg::OP_EVICT, 0, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_random();
		for (int i = 0; i < 400; i++) send_random(7);
		for (int i = 0; i < 100; i++) send_random(2);
	endtask

	task automatic test_no_idle();
		idle_on = 0;
		for (int i = 0; i < 60; i++) send_random(4);
	endtask

	initial begin
		for (int s = 0; s < Slots; s++) begin
			m_valid[s] = 0; m_pin[s] = 0; m_acc[s] = 0; m_backed[s] = 0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		test_directed();
		test_table_full();
		test_random();
		test_no_idle();
		in_valid <= 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
